FILE: hw/rtl/bbb_pkg.sv
// bbb_pkg: shared types and constants for the bipartite byte buffer
// used by bbb_alu, bbb_ctrl and the top level bipartite_byte_buffer
`default_nettype none

package bbb_pkg;

    localparam int DEPTH       = 4096;
    localparam int CHUNK_BYTES = 8;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = 13;
    localparam int DATA_W      = 64;
    localparam int IDX_W       = $clog2(CHUNK_BYTES + 1);
    localparam int BYTE_W      = $clog2(CHUNK_BYTES);

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_DROP  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_NO_ROOM  = 2'd1,
        STAT_TOO_LONG = 2'd2
    } status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] sum;
        logic             lt;
        logic [CNT_W-1:0] sat;
        logic [CNT_W-1:0] min;
    } alu_rsp_t;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] read_bytes;
        logic [CNT_W-1:0]  fill_level;
        logic [CNT_W-1:0]  free_space;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bbb_ram.sv
// bbb_ram: generic single write port, single read port ram
// registered read data; no dependencies
`default_nettype none

module bbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bbb_alu.sv
// bbb_alu: the shared add / subtract / compare unit of the buffer
// depends on bbb_pkg
`default_nettype none

module bbb_alu import bbb_pkg::*; (
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);

    logic [CNT_W:0]   diff;
    logic [CNT_W-1:0] add;

    always_comb begin
        diff    = {1'b0, req.a} - {1'b0, req.b};
        add     = req.a + req.b;
        rsp.lt  = diff[CNT_W];
        rsp.sum = (req.op == ALU_ADD) ? add : diff[CNT_W-1:0];
        rsp.sat = diff[CNT_W] ? '0 : diff[CNT_W-1:0];
        rsp.min = diff[CNT_W] ? req.a : req.b;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bbb_ctrl.sv
// bbb_ctrl: sequencer and region registers of the bipartite byte buffer
// drives the shared bbb_alu and the byte store ram; depends on bbb_pkg
`default_nettype none

module bbb_ctrl import bbb_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_kind,
    input  wire logic [CNT_W-1:0]  s_length,
    input  wire logic [DATA_W-1:0] s_payload,
    input  wire logic              out_busy,
    output logic                   res_valid,
    output result_t                res,
    output alu_req_t               alu_req,
    input  wire alu_rsp_t          alu_rsp,
    output logic                   ram_we,
    output logic [ADDR_W-1:0]      ram_waddr,
    output logic [7:0]             ram_wdata,
    output logic [ADDR_W-1:0]      ram_raddr,
    input  wire logic [7:0]        ram_rdata
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK,
        ST_W_AEND, ST_W_AROOM, ST_W_OPEN, ST_W_BEND, ST_W_BROOM, ST_W_FIT,
        ST_W_BYTE, ST_W_UPD,
        ST_R_TOTAL, ST_R_CHK, ST_R_ISSUE, ST_R_CAPT,
        ST_C_TAKEA, ST_C_FSA, ST_C_FZA, ST_C_NREM, ST_C_TAKEB, ST_C_SSB,
        ST_C_SZB, ST_C_CMP,
        ST_M_RUN, ST_M_FIN,
        ST_P_FILL, ST_P_BEND, ST_P_BROOM, ST_P_AEND, ST_P_AROOM, ST_P_ACMP,
        ST_DONE
    } state_t;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CHUNK_C = CNT_W'(CHUNK_BYTES);

    state_t            state_reg, state_next;
    kind_t             kind_reg, kind_next;
    status_t           status_reg, status_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic [CNT_W-1:0]  t_reg, t_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]  fs_reg, fs_next;
    logic [CNT_W-1:0]  fz_reg, fz_next;
    logic              sa_reg, sa_next;
    logic [CNT_W-1:0]  ss_reg, ss_next;
    logic [CNT_W-1:0]  sz_reg, sz_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  wk_reg, wk_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  space_reg, space_next;
    logic              too_long;
    logic [IDX_W-1:0]  cnt_inc;

    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        len_next    = len_reg;
        n_next      = n_reg;
        r_next      = r_reg;
        t_next      = t_reg;
        addr_next   = addr_reg;
        cnt_next    = cnt_reg;
        data_next   = data_reg;
        acc_next    = acc_reg;
        fs_next     = fs_reg;
        fz_next     = fz_reg;
        sa_next     = sa_reg;
        ss_next     = ss_reg;
        sz_next     = sz_reg;
        k_next      = k_reg;
        wk_next     = wk_reg;
        pend_next   = pend_reg;
        fill_next   = fill_reg;
        space_next  = space_reg;
        alu_req     = '{op: ALU_ADD, a: '0, b: '0};
        ram_we      = 1'b0;
        ram_waddr   = addr_reg[ADDR_W-1:0];
        ram_wdata   = data_reg[7:0];
        ram_raddr   = addr_reg[ADDR_W-1:0];
        res_valid   = 1'b0;
        s_ready     = 1'b0;
        too_long    = len_reg > CHUNK_C;
        cnt_inc     = cnt_reg + 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next   = kind_t'(s_kind);
                    len_next    = s_length;
                    n_next      = s_length;
                    data_next   = s_payload;
                    acc_next    = '0;
                    cnt_next    = '0;
                    status_next = STAT_DONE;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                case (kind_reg)
                    KIND_WRITE: begin
                        if (too_long) begin
                            status_next = STAT_TOO_LONG;
                            state_next  = ST_P_FILL;
                        end else begin
                            state_next = ST_W_AEND;
                        end
                    end
                    KIND_READ: begin
                        if (too_long) begin
                            status_next = STAT_TOO_LONG;
                            state_next  = ST_P_FILL;
                        end else begin
                            state_next = ST_R_TOTAL;
                        end
                    end
                    KIND_DROP: state_next = ST_C_TAKEA;
                    default:   state_next = ST_P_FILL;
                endcase
            end

            // write: find the target region and its room
            ST_W_AEND: begin
                alu_req    = '{op: ALU_ADD, a: fs_reg, b: fz_reg};
                t_next     = alu_rsp.sum;
                state_next = ST_W_AROOM;
            end
            ST_W_AROOM: begin
                alu_req    = '{op: ALU_SUB, a: DEPTH_C, b: t_reg};
                r_next     = alu_rsp.sat;
                state_next = ST_W_OPEN;
            end
            ST_W_OPEN: begin
                alu_req = '{op: ALU_SUB, a: r_reg, b: fs_reg};
                if (sa_reg) begin
                    state_next = ST_W_BEND;
                end else if (alu_rsp.lt) begin
                    // more room before A than after it: open B at the store start
                    sa_next    = 1'b1;
                    ss_next    = '0;
                    sz_next    = '0;
                    state_next = ST_W_BEND;
                end else begin
                    state_next = ST_W_FIT;
                end
            end
            ST_W_BEND: begin
                alu_req    = '{op: ALU_ADD, a: ss_reg, b: sz_reg};
                t_next     = alu_rsp.sum;
                state_next = ST_W_BROOM;
            end
            ST_W_BROOM: begin
                alu_req    = '{op: ALU_SUB, a: fs_reg, b: t_reg};
                r_next     = alu_rsp.sat;
                state_next = ST_W_FIT;
            end
            ST_W_FIT: begin
                alu_req = '{op: ALU_SUB, a: r_reg, b: len_reg};
                if (alu_rsp.lt) begin
                    status_next = STAT_NO_ROOM;
                    state_next  = ST_P_FILL;
                end else begin
                    addr_next  = t_reg;
                    state_next = ST_W_BYTE;
                end
            end
            ST_W_BYTE: begin
                if (cnt_reg == len_reg[IDX_W-1:0]) begin
                    state_next = ST_W_UPD;
                end else begin
                    ram_we    = 1'b1;
                    alu_req   = '{op: ALU_ADD, a: addr_reg, b: CNT_W'(1)};
                    addr_next = alu_rsp.sum;
                    data_next = data_reg >> 8;
                    cnt_next  = cnt_inc;
                end
            end
            ST_W_UPD: begin
                alu_req = '{op: ALU_ADD, a: (sa_reg ? sz_reg : fz_reg), b: len_reg};
                if (sa_reg) begin
                    sz_next = alu_rsp.sum;
                end else begin
                    fz_next = alu_rsp.sum;
                end
                state_next = ST_P_FILL;
            end

            // read: all or nothing
            ST_R_TOTAL: begin
                alu_req    = '{op: ALU_ADD, a: fz_reg, b: sz_reg};
                t_next     = alu_rsp.sum;
                state_next = ST_R_CHK;
            end
            ST_R_CHK: begin
                alu_req = '{op: ALU_SUB, a: t_reg, b: len_reg};
                if (alu_rsp.lt) begin
                    status_next = STAT_NO_ROOM;
                    state_next  = ST_P_FILL;
                end else begin
                    state_next = ST_C_TAKEA;
                end
            end
            ST_R_ISSUE: begin
                if (cnt_reg == len_reg[IDX_W-1:0]) begin
                    state_next = ST_C_FSA;
                end else begin
                    alu_req    = '{op: ALU_ADD, a: addr_reg, b: CNT_W'(1)};
                    addr_next  = alu_rsp.sum;
                    state_next = ST_R_CAPT;
                end
            end
            ST_R_CAPT: begin
                acc_next[8*cnt_reg[BYTE_W-1:0] +: 8] = ram_rdata;
                cnt_next = cnt_inc;
                // A part used up: carry on from the front of B
                if (CNT_W'(cnt_inc) == r_reg) begin
                    addr_next = ss_reg;
                end
                state_next = ST_R_ISSUE;
            end

            // consume from A, then from B (read and drop)
            ST_C_TAKEA: begin
                alu_req   = '{op: ALU_SUB, a: n_reg, b: fz_reg};
                r_next    = alu_rsp.min;
                addr_next = (fz_reg == '0) ? ss_reg : fs_reg;
                state_next = (kind_reg == KIND_READ) ? ST_R_ISSUE : ST_C_FSA;
            end
            ST_C_FSA: begin
                alu_req    = '{op: ALU_ADD, a: fs_reg, b: r_reg};
                fs_next    = alu_rsp.sum;
                state_next = ST_C_FZA;
            end
            ST_C_FZA: begin
                alu_req    = '{op: ALU_SUB, a: fz_reg, b: r_reg};
                fz_next    = alu_rsp.sum;
                state_next = ST_C_NREM;
            end
            ST_C_NREM: begin
                alu_req    = '{op: ALU_SUB, a: n_reg, b: r_reg};
                n_next     = alu_rsp.sum;
                state_next = ST_C_TAKEB;
            end
            ST_C_TAKEB: begin
                alu_req    = '{op: ALU_SUB, a: n_reg, b: sz_reg};
                r_next     = alu_rsp.min;
                state_next = ST_C_SSB;
            end
            ST_C_SSB: begin
                alu_req    = '{op: ALU_ADD, a: ss_reg, b: r_reg};
                ss_next    = alu_rsp.sum;
                state_next = ST_C_SZB;
            end
            ST_C_SZB: begin
                alu_req    = '{op: ALU_SUB, a: sz_reg, b: r_reg};
                sz_next    = alu_rsp.sum;
                state_next = ST_C_CMP;
            end
            ST_C_CMP: begin
                if (fz_reg != '0) begin
                    state_next = ST_P_FILL;
                end else if (sz_reg != '0 && ss_reg != '0) begin
                    k_next     = '0;
                    wk_next    = '0;
                    pend_next  = 1'b0;
                    state_next = ST_M_RUN;
                end else begin
                    state_next = ST_M_FIN;
                end
            end

            // copy B down to the store start, one byte a cycle
            ST_M_RUN: begin
                alu_req   = '{op: ALU_ADD, a: ss_reg, b: k_reg};
                ram_raddr = alu_rsp.sum[ADDR_W-1:0];
                ram_we    = pend_reg;
                ram_waddr = wk_reg[ADDR_W-1:0];
                ram_wdata = ram_rdata;
                if (pend_reg) begin
                    wk_next = wk_reg + 1'b1;
                end
                if (k_reg != sz_reg) begin
                    k_next    = k_reg + 1'b1;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = ST_M_FIN;
                    end
                end
            end
            ST_M_FIN: begin
                fs_next    = '0;
                fz_next    = sz_reg;
                sa_next    = 1'b0;
                ss_next    = '0;
                sz_next    = '0;
                state_next = ST_P_FILL;
            end

            // fill level and free space after the step
            ST_P_FILL: begin
                alu_req    = '{op: ALU_ADD, a: fz_reg, b: sz_reg};
                fill_next  = alu_rsp.sum;
                state_next = sa_reg ? ST_P_BEND : ST_P_AEND;
            end
            ST_P_BEND: begin
                alu_req    = '{op: ALU_ADD, a: ss_reg, b: sz_reg};
                t_next     = alu_rsp.sum;
                state_next = ST_P_BROOM;
            end
            ST_P_BROOM: begin
                alu_req    = '{op: ALU_SUB, a: fs_reg, b: t_reg};
                space_next = alu_rsp.sat;
                state_next = ST_DONE;
            end
            ST_P_AEND: begin
                alu_req    = '{op: ALU_ADD, a: fs_reg, b: fz_reg};
                t_next     = alu_rsp.sum;
                state_next = ST_P_AROOM;
            end
            ST_P_AROOM: begin
                alu_req    = '{op: ALU_SUB, a: DEPTH_C, b: t_reg};
                r_next     = alu_rsp.sat;
                state_next = ST_P_ACMP;
            end
            ST_P_ACMP: begin
                alu_req    = '{op: ALU_SUB, a: r_reg, b: fs_reg};
                space_next = alu_rsp.lt ? fs_reg : r_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_busy) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        res.status     = status_reg;
        res.read_bytes = acc_reg;
        res.fill_level = fill_reg;
        res.free_space = space_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            kind_reg   <= KIND_WRITE;
            status_reg <= STAT_DONE;
            fs_reg     <= '0;
            fz_reg     <= '0;
            sa_reg     <= 1'b0;
            ss_reg     <= '0;
            sz_reg     <= '0;
            cnt_reg    <= '0;
            k_reg      <= '0;
            wk_reg     <= '0;
            pend_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            status_reg <= status_next;
            fs_reg     <= fs_next;
            fz_reg     <= fz_next;
            sa_reg     <= sa_next;
            ss_reg     <= ss_next;
            sz_reg     <= sz_next;
            cnt_reg    <= cnt_next;
            k_reg      <= k_next;
            wk_reg     <= wk_next;
            pend_reg   <= pend_next;
        end
        len_reg   <= len_next;
        n_reg     <= n_next;
        r_reg     <= r_next;
        t_reg     <= t_next;
        addr_reg  <= addr_next;
        data_reg  <= data_next;
        acc_reg   <= acc_next;
        fill_reg  <= fill_next;
        space_reg <= space_next;
    end

    a_region_a_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> ({1'b0, fs_reg} + {1'b0, fz_reg}) <= (CNT_W+1)'(DEPTH))
        else $error("region A runs past the end of the store");

    a_region_b_below_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && sa_reg) |-> (sz_reg <= fs_reg && fz_reg != '0))
        else $error("region B overlaps A or outlives an empty A");

    a_region_b_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> (ss_reg == '0 && (sa_reg || sz_reg == '0)))
        else $error("region B left off the store start or sized while closed");

    a_no_store_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !ram_we)
        else $error("store written with no item in progress");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (fill_reg <= DEPTH_C && space_reg <= DEPTH_C))
        else $error("reported fill level or free space above the store size");

endmodule

`default_nettype wire

FILE: hw/rtl/bipartite_byte_buffer.sv
// bipartite_byte_buffer: a 4096-byte bip buffer (regions A and B) served one item at a time.
// Input channel s_*: kind (write chunk, read chunk, drop bytes), length, payload bytes.
// Result channel m_*: status, read_bytes, fill_level, free_space; one result per item.
// Both channels use valid/ready; an item moves when valid and ready are high together.
// s_ready is high only while the sequencer is idle; an item is worked through by one
// shared 13-bit add/compare unit, one step per cycle, and bytes move through the
// single-port-pair byte store one at a time.
// A read or drop that empties A and leaves B off the store start also copies the sz
// bytes held in B down to address 0 before the result is given.
// Reset empties both regions at once; the store contents are left as they are and are
// never returned before being written, so there is no clearing pass.
// A single output register holds the result: the next item is accepted and worked on
// while it waits, and only the final hand-over step stalls until m_ready frees the slot.
// depends on bbb_pkg, bbb_ram, bbb_alu, bbb_ctrl
`default_nettype none

module bipartite_byte_buffer import bbb_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_kind,
    input  wire logic [CNT_W-1:0]  s_length,
    input  wire logic [DATA_W-1:0] s_payload,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status,
    output logic [DATA_W-1:0]      m_read_bytes,
    output logic [CNT_W-1:0]       m_fill_level,
    output logic [CNT_W-1:0]       m_free_space
);

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    result_t           res;
    logic              res_valid;
    logic              out_busy;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic              m_valid_reg, m_valid_next;
    result_t           m_res_reg;

    bbb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_length  (s_length),
        .s_payload (s_payload),
        .out_busy  (out_busy),
        .res_valid (res_valid),
        .res       (res),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    bbb_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    bbb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output slot frees in the same cycle the receiver takes the item
    assign out_busy = m_valid_reg && !m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_res_reg.status;
    assign m_read_bytes = m_res_reg.read_bytes;
    assign m_fill_level = m_res_reg.fill_level;
    assign m_free_space = m_res_reg.free_space;

endmodule

`default_nettype wire
